// ===== rtl/core/sbsm_pkg.sv =====
`default_nettype none

package sbsm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_PAGES = 2'd0;
    localparam logic [1:0] CFG_CHR_ROM   = 2'd1;
    localparam logic [1:0] CFG_CHR_RAM   = 2'd2;

    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 8;

    localparam int unsigned S_DW = 24;
    localparam int unsigned M_DW = 48;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;

    localparam logic [7:0] PAGES_1024K = 8'd128;
    localparam logic [7:0] PAGES_512K  = 8'd64;

    localparam logic [4:0] REG0_RESET = 5'h0C;

    // Register windows, from cpu_addr[14:13]
    localparam logic [1:0] WIN_CTRL = 2'd0;
    localparam logic [1:0] WIN_CHR0 = 2'd1;
    localparam logic [1:0] WIN_CHR1 = 2'd2;
    localparam logic [1:0] WIN_PRG  = 2'd3;

    typedef enum logic [1:0] {
        SIZE_SMALL,
        SIZE_512K,
        SIZE_1024K
    } size_t;

    typedef enum logic [1:0] {
        CHR_NONE = 2'd0,
        CHR_ROM  = 2'd1,
        CHR_RAM  = 2'd2
    } chr_src_t;

    typedef struct packed {
        logic [7:0] prg_pages_8k;
        logic       chr_rom_present;
        logic       chr_ram_present;
    } cfg_t;

    // One classified write: commit of a 5-bit value into a register window
    typedef struct packed {
        logic       commit;
        logic [1:0] window;
        logic [4:0] value;
    } cmd_t;

    function automatic size_t size_class(input logic [7:0] pages);
        size_t sz;
        if (pages == PAGES_1024K)
        begin
            sz = SIZE_1024K;
        end
        else if (pages == PAGES_512K)
        begin
            sz = SIZE_512K;
        end
        else
        begin
            sz = SIZE_SMALL;
        end
        return sz;
    endfunction

    // Last two program pages, 5-bit wrap
    function automatic logic [4:0] high_bank(input logic [7:0] pages, input logic k);
        logic [4:0] hb;
        if (size_class(pages) == SIZE_SMALL)
        begin
            hb = pages[4:0] - 5'd2 + {4'b0, k};
        end
        else
        begin
            hb = 5'd30 + {4'b0, k};
        end
        return hb;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbsm_front.sv =====
`default_nettype none

module sbsm_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [15:0]                cpu_addr,
    input  wire logic [7:0]                 cpu_data,
    input  wire logic                       q_ready,
    output logic                            q_push,
    output sbsm_pkg::cmd_t                  q_cmd
);

    logic [2:0] shift_count_reg;
    logic [2:0] shift_count_next;
    logic [4:0] shift_bits_reg;
    logic [4:0] shift_bits_next;
    logic [1:0] last_window_reg;
    logic [1:0] last_window_next;

    logic [1:0] window;
    logic [2:0] cnt;
    logic [4:0] bits;

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;
    assign window   = cpu_addr[14:13];

    always_comb
    begin
        cnt              = shift_count_reg;
        bits             = shift_bits_reg;
        q_cmd.commit     = 1'b0;
        q_cmd.window     = window;
        q_cmd.value      = '0;
        // a window change drops the partial value
        if (window != last_window_reg)
        begin
            cnt  = '0;
            bits = '0;
        end
        if (cpu_data[7])
        begin
            cnt  = '0;
            bits = '0;
        end
        else
        begin
            bits = bits | (5'(cpu_data[0]) << cnt);
            cnt  = cnt + 3'd1;
            if (cnt == 3'd5)
            begin
                q_cmd.commit = 1'b1;
                q_cmd.value  = bits;
                cnt          = '0;
                bits         = '0;
            end
        end
        shift_count_next = cnt;
        shift_bits_next  = bits;
        last_window_next = window;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_count_reg <= '0;
            shift_bits_reg  <= '0;
            last_window_reg <= '0;
        end
        else if (q_push)
        begin
            shift_count_reg <= shift_count_next;
            shift_bits_reg  <= shift_bits_next;
            last_window_reg <= last_window_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbsm_queue.sv =====
`default_nettype none

module sbsm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sbsm_pkg::cmd_t  push_cmd,
    output logic                 not_full,
    input  wire logic            pop,
    output logic                 not_empty,
    output sbsm_pkg::cmd_t       pop_cmd
);

    localparam int unsigned CW = sbsm_pkg::QUEUE_AW + 1;

    sbsm_pkg::cmd_t                  mem_reg [sbsm_pkg::QUEUE_DEPTH];
    logic [sbsm_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [sbsm_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;

    assign not_full  = (count_reg != CW'(sbsm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbsm_back.sv =====
`default_nettype none

module sbsm_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sbsm_pkg::cfg_t                cfg,
    input  wire logic                          q_valid,
    input  wire sbsm_pkg::cmd_t                q_cmd,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sbsm_pkg::M_DW-1:0]          out_data
);

    logic [4:0] mapper_regs_reg [4];
    logic [4:0] mapper_regs_next [4];
    logic [1:0] outer_base_reg;
    logic [1:0] outer_base_next;
    logic       swap_pending_reg;
    logic       swap_pending_next;
    logic [4:0] prg_banks_reg [4];
    logic [4:0] prg_banks_next [4];
    logic [7:0] chr_bases_reg [2];
    logic [7:0] chr_bases_next [2];
    logic [1:0] mirror_reg;
    logic [1:0] mirror_next;
    logic                      out_valid_reg;
    logic [sbsm_pkg::M_DW-1:0] out_data_reg;
    logic [sbsm_pkg::M_DW-1:0] out_data_next;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        sbsm_pkg::size_t    sz;
        sbsm_pkg::chr_src_t src;
        logic [4:0] r0;
        logic [4:0] r1;
        logic [4:0] r2;
        logic [4:0] b;
        logic       chr_any;
        logic       toggle;
        logic       use_reg2;

        mapper_regs_next  = mapper_regs_reg;
        outer_base_next   = outer_base_reg;
        swap_pending_next = swap_pending_reg;
        prg_banks_next    = prg_banks_reg;
        chr_bases_next    = chr_bases_reg;
        mirror_next       = mirror_reg;
        toggle            = 1'b0;
        use_reg2          = 1'b0;

        sz      = sbsm_pkg::size_class(cfg.prg_pages_8k);
        chr_any = cfg.chr_rom_present || cfg.chr_ram_present;

        if (q_cmd.commit)
        begin
            mapper_regs_next[q_cmd.window] = q_cmd.value;
        end
        r0 = mapper_regs_next[0];
        r1 = mapper_regs_next[1];
        r2 = mapper_regs_next[2];
        b  = {mapper_regs_next[3][3:0], 1'b0};

        if (q_cmd.commit)
        begin
            unique case (q_cmd.window)
                sbsm_pkg::WIN_CTRL:
                begin
                    mirror_next = r0[1:0];
                end
                sbsm_pkg::WIN_CHR0:
                begin
                    if (sz == sbsm_pkg::SIZE_1024K)
                    begin
                        if (r0[4])
                        begin
                            toggle   = 1'b1;
                            use_reg2 = r0[3];
                        end
                        else
                        begin
                            outer_base_next = r1[4] ? 2'd3 : 2'd0;
                        end
                    end
                    else if (sz == sbsm_pkg::SIZE_512K && !cfg.chr_rom_present)
                    begin
                        outer_base_next = {1'b0, r1[4]};
                    end
                    else if (chr_any)
                    begin
                        chr_bases_next[0] = {1'b0, r1, 2'b00};
                        if (!r0[4])
                        begin
                            chr_bases_next[1] = {1'b0, r1, 2'b00} + 8'd4;
                        end
                    end
                end
                sbsm_pkg::WIN_CHR1:
                begin
                    if (sz == sbsm_pkg::SIZE_1024K && r0[3])
                    begin
                        toggle   = 1'b1;
                        use_reg2 = 1'b1;
                    end
                    if (r0[4] && chr_any)
                    begin
                        chr_bases_next[1] = {1'b0, r2, 2'b00};
                    end
                end
                sbsm_pkg::WIN_PRG:
                begin
                    if (r0[3])
                    begin
                        if (r0[2])
                        begin
                            prg_banks_next[0] = b;
                            prg_banks_next[1] = b + 5'd1;
                            prg_banks_next[2] = sbsm_pkg::high_bank(cfg.prg_pages_8k, 1'b0);
                            prg_banks_next[3] = sbsm_pkg::high_bank(cfg.prg_pages_8k, 1'b1);
                        end
                        else if (sz == sbsm_pkg::SIZE_SMALL)
                        begin
                            prg_banks_next[0] = 5'd0;
                            prg_banks_next[1] = 5'd1;
                            prg_banks_next[2] = b;
                            prg_banks_next[3] = b + 5'd1;
                        end
                    end
                    else
                    begin
                        prg_banks_next[0] = b;
                        prg_banks_next[1] = b + 5'd1;
                        if (sz == sbsm_pkg::SIZE_SMALL)
                        begin
                            prg_banks_next[2] = b + 5'd2;
                            prg_banks_next[3] = b + 5'd3;
                        end
                    end
                end
                default:
                begin
                    mirror_next = mirror_reg;
                end
            endcase
        end

        // two-write swap: first arms, second loads the outer base
        if (toggle)
        begin
            if (swap_pending_reg)
            begin
                outer_base_next   = {use_reg2 & r2[4], r1[4]};
                swap_pending_next = 1'b0;
            end
            else
            begin
                swap_pending_next = 1'b1;
            end
        end

        if (cfg.chr_rom_present)
        begin
            src = sbsm_pkg::CHR_ROM;
        end
        else if (cfg.chr_ram_present)
        begin
            src = sbsm_pkg::CHR_RAM;
        end
        else
        begin
            src = sbsm_pkg::CHR_NONE;
        end

        out_data_next = {src, mirror_next, chr_bases_next[1], chr_bases_next[0],
                         outer_base_next, prg_banks_next[3],
                         outer_base_next, prg_banks_next[2],
                         outer_base_next, prg_banks_next[1],
                         outer_base_next, prg_banks_next[0]};
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_regs_reg[0] <= sbsm_pkg::REG0_RESET;
            mapper_regs_reg[1] <= '0;
            mapper_regs_reg[2] <= '0;
            mapper_regs_reg[3] <= '0;
            outer_base_reg     <= '0;
            swap_pending_reg   <= 1'b0;
            prg_banks_reg[0]   <= 5'd0;
            prg_banks_reg[1]   <= 5'd1;
            prg_banks_reg[2]   <= 5'd30;
            prg_banks_reg[3]   <= 5'd31;
            chr_bases_reg[0]   <= 8'd0;
            chr_bases_reg[1]   <= 8'd4;
            mirror_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mapper_regs_reg  <= mapper_regs_next;
                outer_base_reg   <= outer_base_next;
                swap_pending_reg <= swap_pending_next;
                prg_banks_reg    <= prg_banks_next;
                chr_bases_reg    <= chr_bases_next;
                mirror_reg       <= mirror_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/serial_bank_switch_mapper.sv =====
// Path: an accepted word is written into the command queue, then popped through the mapper state
// into the output register; back-pressure on m_tready can hold it in the queue.
// Throughput: one word per cycle while m_tready allows; the mapper state updates on each pop.
// Reset (rst_n low, asynchronous): shifter empty, register 0 = 0x0C, banks 0/1/30/31,
// character bases 0 and 4, one-screen low mirroring, configuration 32 pages, ROM present.
`default_nettype none

module serial_bank_switch_mapper (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // s_tdata: cpu_addr[15:0], cpu_data[23:16]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sbsm_pkg::S_DW-1:0]      s_tdata,
    // m_tdata: prg_page_0[6:0], prg_page_1[13:7], prg_page_2[20:14], prg_page_3[27:21],
    //          chr_low_base[35:28], chr_high_base[43:36], mirror_mode[45:44],
    //          chr_source[47:46]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sbsm_pkg::M_DW-1:0]           m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [sbsm_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [sbsm_pkg::CFG_DW-1:0]    cfg_wdata
);

    logic [7:0] prg_pages_reg;
    logic       chr_rom_reg;
    logic       chr_ram_reg;

    sbsm_pkg::cfg_t cfg;
    sbsm_pkg::cmd_t push_cmd;
    sbsm_pkg::cmd_t pop_cmd;
    logic           q_push;
    logic           q_not_full;
    logic           q_not_empty;
    logic           q_pop;

    assign cfg.prg_pages_8k    = prg_pages_reg;
    assign cfg.chr_rom_present = chr_rom_reg;
    assign cfg.chr_ram_present = chr_ram_reg;

    // Configuration registers; a write to an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_pages_reg <= 8'd32;
            chr_rom_reg   <= 1'b1;
            chr_ram_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sbsm_pkg::CFG_PRG_PAGES: prg_pages_reg <= cfg_wdata;
                sbsm_pkg::CFG_CHR_ROM:   chr_rom_reg   <= cfg_wdata[0];
                sbsm_pkg::CFG_CHR_RAM:   chr_ram_reg   <= cfg_wdata[0];
                default:                 prg_pages_reg <= prg_pages_reg;
            endcase
        end
    end

    // Front: track the serial shifter and turn each write into a command
    sbsm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cpu_addr (s_tdata[15:0]),
        .cpu_data (s_tdata[23:16]),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Short command queue so the back end can stall on m_tready independently
    sbsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    // Back: apply register commits and register the mapping snapshot
    sbsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_not_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
